>>> hdl/htsr_pkg.sv
package htsr_pkg;

  // Width of the internal run character counter (8 to 32).
  localparam int unsigned RunCountBits = 16;
  localparam int unsigned RunLenBits   = 16;

  // Result queue, counted in whole input bytes. Keep it a power of two.
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrBits     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntBits     = $clog2(QueueDepth + 1);

  // Most result beats one input byte can cause.
  localparam int unsigned MaxResults   = 4;
  localparam int unsigned ResIdxBits   = $clog2(MaxResults);
  localparam int unsigned ResCntBits   = $clog2(MaxResults + 1);

  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;

  localparam logic [2:0] HeadCloseLen = 3'd7;

  typedef enum logic {
    KindText  = 1'b0,
    KindBreak = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            text_byte;
    logic [RunLenBits-1:0] run_length;
    logic                  last_of_item;
    logic                  document_end;
  } result_t;

  // All results caused by one input byte, in order.
  typedef struct packed {
    logic [ResIdxBits-1:0]          n_minus1;
    result_t [MaxResults-1:0]       res;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } push_t;

  // Expected byte of "</head>" at a given match position.
  function automatic logic [7:0] head_close_char(logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = ChLt;
      3'd1:    ch = ChSlash;
      3'd2:    ch = ChH;
      3'd3:    ch = ChE;
      3'd4:    ch = ChA;
      3'd5:    ch = ChD;
      3'd6:    ch = ChGt;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Clamp the run counter to the reported width.
  function automatic logic [RunLenBits-1:0] sat_len(logic [RunCountBits-1:0] c);
    logic [RunCountBits+RunLenBits-1:0] w;
    logic [RunCountBits+RunLenBits-1:0] lim;
    w   = {{RunLenBits{1'b0}}, c};
    lim = {{RunCountBits{1'b0}}, {RunLenBits{1'b1}}};
    if (w > lim) begin
      return {RunLenBits{1'b1}};
    end
    return w[RunLenBits-1:0];
  endfunction

endpackage

>>> hdl/htsr_scan.sv
module htsr_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              is_final_i,
  output htsr_pkg::push_t   push_o
);

  typedef enum logic [11:0] {
    ModeText      = 12'b0000_0000_0001,
    ModeLt        = 12'b0000_0000_0010,
    ModeLtH       = 12'b0000_0000_0100,
    ModeLtHe      = 12'b0000_0000_1000,
    ModeLtHea     = 12'b0000_0001_0000,
    ModeLtB       = 12'b0000_0010_0000,
    ModeLtL       = 12'b0000_0100_0000,
    ModeLtD       = 12'b0000_1000_0000,
    ModeBreakTag  = 12'b0001_0000_0000,
    ModeListTag   = 12'b0010_0000_0000,
    ModeOtherTag  = 12'b0100_0000_0000,
    ModeHeadSkip  = 12'b1000_0000_0000
  } mode_e;

  localparam logic [htsr_pkg::RunCountBits-1:0] CntMax = '1;

  mode_e                             mode_q, mode_d;
  logic [2:0]                        prog_q, prog_d;
  logic                              blank_q, blank_d;
  logic [htsr_pkg::RunCountBits-1:0] cnt_q, cnt_d;

  logic                              emit_text, emit_brk, emit_list;
  logic [7:0]                        text_val;
  logic [htsr_pkg::ResCntBits-1:0]   n;
  htsr_pkg::result_t [htsr_pkg::MaxResults-1:0] res;

  // Scanner step: next mode and what this byte emits before end handling.
  always_comb begin
    mode_d    = mode_q;
    prog_d    = prog_q;
    blank_d   = blank_q;
    emit_text = 1'b0;
    emit_brk  = 1'b0;
    emit_list = 1'b0;
    text_val  = in_byte_i;
    case (mode_q)
      ModeText: begin
        if (in_byte_i == htsr_pkg::ChLt) begin
          mode_d = ModeLt;
        end else if (in_byte_i inside {htsr_pkg::ChSpace, htsr_pkg::ChLf, htsr_pkg::ChTab})
        begin
          if (!blank_q) begin
            emit_text = 1'b1;
            text_val  = htsr_pkg::ChSpace;
            blank_d   = 1'b1;
          end
        end else if (in_byte_i > htsr_pkg::ChSpace) begin
          emit_text = 1'b1;
          blank_d   = 1'b0;
        end
      end
      ModeLt: begin
        case (in_byte_i)
          htsr_pkg::ChH:  mode_d = ModeLtH;
          htsr_pkg::ChP:  mode_d = ModeBreakTag;
          htsr_pkg::ChB:  mode_d = ModeLtB;
          htsr_pkg::ChL:  mode_d = ModeLtL;
          htsr_pkg::ChD:  mode_d = ModeLtD;
          htsr_pkg::ChGt: mode_d = ModeText;
          default:        mode_d = ModeOtherTag;
        endcase
      end
      ModeLtH, ModeLtHe, ModeLtHea: begin
        if (in_byte_i == htsr_pkg::ChGt) begin
          emit_brk = 1'b1;
          mode_d   = ModeText;
        end else if (mode_q == ModeLtH && in_byte_i == htsr_pkg::ChE) begin
          mode_d = ModeLtHe;
        end else if (mode_q == ModeLtHe && in_byte_i == htsr_pkg::ChA) begin
          mode_d = ModeLtHea;
        end else if (mode_q == ModeLtHea && in_byte_i == htsr_pkg::ChD) begin
          mode_d = ModeHeadSkip;
          prog_d = 3'd0;
        end else begin
          mode_d = ModeBreakTag;
        end
      end
      ModeLtB: begin
        if (in_byte_i == htsr_pkg::ChR) begin
          mode_d = ModeBreakTag;
        end else if (in_byte_i == htsr_pkg::ChGt) begin
          mode_d = ModeText;
        end else begin
          mode_d = ModeOtherTag;
        end
      end
      ModeLtL, ModeLtD: begin
        if ((mode_q == ModeLtL && in_byte_i == htsr_pkg::ChI) ||
            (mode_q == ModeLtD && (in_byte_i == htsr_pkg::ChT || in_byte_i == htsr_pkg::ChL)))
        begin
          mode_d = ModeListTag;
        end else if (in_byte_i == htsr_pkg::ChGt) begin
          mode_d = ModeText;
        end else begin
          mode_d = ModeOtherTag;
        end
      end
      ModeBreakTag: begin
        if (in_byte_i == htsr_pkg::ChGt) begin
          emit_brk = 1'b1;
          mode_d   = ModeText;
        end
      end
      ModeListTag: begin
        if (in_byte_i == htsr_pkg::ChGt) begin
          emit_list = 1'b1;
          mode_d    = ModeText;
        end
      end
      ModeOtherTag: begin
        if (in_byte_i == htsr_pkg::ChGt) begin
          mode_d = ModeText;
        end
      end
      ModeHeadSkip: begin
        if (prog_q < htsr_pkg::HeadCloseLen &&
            in_byte_i == htsr_pkg::head_close_char(prog_q)) begin
          if (prog_q + 3'd1 >= htsr_pkg::HeadCloseLen) begin
            prog_d = 3'd0;
            mode_d = ModeText;
          end else begin
            prog_d = prog_q + 3'd1;
          end
        end else begin
          prog_d = (in_byte_i == htsr_pkg::ChLt) ? 3'd1 : 3'd0;
        end
      end
      default: begin
        mode_d = ModeText;
      end
    endcase

    // Assemble the result beats and the run count after them.
    res   = '0;
    n     = '0;
    cnt_d = cnt_q;
    if (emit_brk || emit_list) begin
      res[0].kind       = htsr_pkg::KindBreak;
      res[0].run_length = htsr_pkg::sat_len(cnt_q);
      cnt_d             = '0;
      n                 = htsr_pkg::ResCntBits'(1);
    end
    if (emit_list) begin
      res[1].kind      = htsr_pkg::KindText;
      res[1].text_byte = htsr_pkg::ChStar;
      res[2].kind      = htsr_pkg::KindText;
      res[2].text_byte = htsr_pkg::ChSpace;
      cnt_d            = htsr_pkg::RunCountBits'(2);
      n                = htsr_pkg::ResCntBits'(3);
    end
    if (emit_text) begin
      res[0].kind      = htsr_pkg::KindText;
      res[0].text_byte = text_val;
      cnt_d            = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
      n                = htsr_pkg::ResCntBits'(1);
    end
    if (is_final_i) begin
      res[n[htsr_pkg::ResIdxBits-1:0]].kind         = htsr_pkg::KindBreak;
      res[n[htsr_pkg::ResIdxBits-1:0]].run_length   = htsr_pkg::sat_len(cnt_d);
      res[n[htsr_pkg::ResIdxBits-1:0]].document_end = 1'b1;
      n       = n + 1'b1;
      // end of document: drop any open tag or head section
      cnt_d   = '0;
      mode_d  = ModeText;
      prog_d  = 3'd0;
      blank_d = 1'b0;
    end
    if (n != '0) begin
      res[htsr_pkg::ResIdxBits'(n - 1'b1)].last_of_item = 1'b1;
    end
  end

  assign push_o.push            = accept_i && (n != '0);
  assign push_o.bundle.n_minus1 = htsr_pkg::ResIdxBits'(n - 1'b1);
  assign push_o.bundle.res      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeText;
      prog_q  <= 3'd0;
      blank_q <= 1'b0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      prog_q  <= prog_d;
      blank_q <= blank_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hdl/htsr_outq.sv
module htsr_outq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  htsr_pkg::push_t                      push_i,
  output logic                                 full_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output htsr_pkg::result_t                    out_res_o
);

  htsr_pkg::bundle_t                 mem_q [htsr_pkg::QueueDepth];
  logic [htsr_pkg::QPtrBits-1:0]     wr_ptr_q, rd_ptr_q;
  logic [htsr_pkg::QCntBits-1:0]     cnt_q;
  logic [htsr_pkg::ResIdxBits-1:0]   idx_q;
  htsr_pkg::bundle_t                 head;
  logic                              beat, pop;

  assign head        = mem_q[rd_ptr_q];
  assign full_o      = (cnt_q == htsr_pkg::QCntBits'(htsr_pkg::QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = head.res[idx_q];

  // Step through the head bundle; drop it after its last beat.
  assign beat = out_valid_o && !out_stall_i;
  assign pop  = beat && (idx_q == head.n_minus1);

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.bundle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
        idx_q    <= '0;
      end else if (beat) begin
        idx_q <= idx_q + 1'b1;
      end
      if (push_i.push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i.push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/html_tag_strip_run_splitter.sv
// The result queue registers the beats of each accepted byte before the output port.
// Throughput: one byte per cycle while the output is not stalled and each byte gives
// at most one result beat; the beats of one byte leave the single output port in turn,
// and input stalls when the two-entry result queue (one entry per byte) is full.
// Reset: rst_ni is asynchronous, active low; it returns the scanner to plain text,
// clears the blank flag and run count, and empties the result queue.
module html_tag_strip_run_splitter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        in_byte_i,
  input  logic                              is_final_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              kind_o,
  output logic [7:0]                        text_byte_o,
  output logic [htsr_pkg::RunLenBits-1:0]   run_length_o,
  output logic                              last_of_item_o,
  output logic                              document_end_o
);

  logic              accept;
  logic              q_full;
  htsr_pkg::push_t   push;
  htsr_pkg::result_t cur;

  // Take a beat whenever the queue has a free entry, regardless of what the
  // output side is doing this cycle.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  // Scanner: holds the tag-matching state and turns one byte into a bundle
  // of zero to four result beats combinationally.
  htsr_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .is_final_i (is_final_i),
    .push_o     (push)
  );

  // Result queue: absorbs the bundles and serializes them, one beat per unstalled cycle.
  htsr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (cur)
  );

  assign kind_o         = cur.kind;
  assign text_byte_o    = cur.text_byte;
  assign run_length_o   = cur.run_length;
  assign last_of_item_o = cur.last_of_item;
  assign document_end_o = cur.document_end;

`ifndef ASSERT_OFF
  // The document end marker only rides on the closing break of a byte.
  a_end_is_last_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && document_end_o |-> kind_o && last_of_item_o)
    else $error("document end on a beat that is not the final break");

  // Text beats carry no run length.
  a_text_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> run_length_o == '0 && !document_end_o)
    else $error("text beat carries break fields");

  // Break beats carry no text byte.
  a_break_no_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> text_byte_o == 8'h00)
    else $error("break beat carries a text byte");

  // A final byte always leaves a result waiting in the next cycle.
  a_final_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && is_final_i |=> out_valid_o)
    else $error("final byte produced no result beat");
`endif

endmodule

>>> verif/htsr_checker.sv
module htsr_checker
  import htsr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  is_final_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  kind_i,
  input  logic [7:0]            text_byte_i,
  input  logic [RunLenBits-1:0] run_length_i,
  input  logic                  last_of_item_i,
  input  logic                  document_end_i,
  output int                    error_count_o,
  output int                    results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    ScanText,
    ScanLt,
    ScanLtH,
    ScanLtHe,
    ScanLtHea,
    ScanLtB,
    ScanLtL,
    ScanLtD,
    ScanBreakTag,
    ScanListTag,
    ScanOtherTag,
    ScanHeadSkip
  } scan_mode_e;

  localparam longint unsigned CountMax = (64'd1 << RunCountBits) - 1;
  localparam longint unsigned LenMax   = (64'd1 << RunLenBits) - 1;
  localparam logic [55:0] HeadClosePat = {ChLt, ChSlash, ChH, ChE, ChA, ChD, ChGt};

  scan_mode_e       scan_mode;
  logic [2:0]       head_match;
  logic             blank_seen;
  longint unsigned  run_chars;
  result_t          item_beats[$];
  result_t          expected_beats[$];
  result_t          want;
  int               errors = 0;

  initial begin
    error_count_o = 0;
    results_due_o = 0;
  end

  function automatic void clear_scan();
    scan_mode  = ScanText;
    head_match = '0;
    blank_seen = 1'b0;
    run_chars  = 0;
  endfunction

  function automatic void add_text(logic [7:0] ch);
    result_t r;
    r           = '0;
    r.kind      = KindText;
    r.text_byte = ch;
    item_beats  = {item_beats, r};
    if (run_chars < CountMax) run_chars++;
  endfunction

  function automatic void add_break(logic doc_end);
    result_t          r;
    longint unsigned  len;
    len            = (run_chars > LenMax) ? LenMax : run_chars;
    r              = '0;
    r.kind         = KindBreak;
    r.run_length   = len[RunLenBits-1:0];
    r.document_end = doc_end;
    item_beats     = {item_beats, r};
    run_chars = 0;
  endfunction

  // Work out every beat one document byte causes and queue them in order.
  function automatic void strip_and_split(logic [7:0] ch, logic fin);
    int pos;
    item_beats.delete();
    case (scan_mode)
      ScanText: begin
        if (ch == ChLt) begin
          scan_mode = ScanLt;
        end else if (ch == ChSpace || ch == ChLf || ch == ChTab) begin
          if (!blank_seen) begin
            add_text(ChSpace);
            blank_seen = 1'b1;
          end
        end else if (ch > ChSpace) begin
          add_text(ch);
          blank_seen = 1'b0;
        end
      end
      ScanLt: begin
        if (ch == ChH) scan_mode = ScanLtH;
        else if (ch == ChP) scan_mode = ScanBreakTag;
        else if (ch == ChB) scan_mode = ScanLtB;
        else if (ch == ChL) scan_mode = ScanLtL;
        else if (ch == ChD) scan_mode = ScanLtD;
        else if (ch == ChGt) scan_mode = ScanText;
        else scan_mode = ScanOtherTag;
      end
      ScanLtH, ScanLtHe, ScanLtHea: begin
        if (ch == ChGt) begin
          add_break(1'b0);
          scan_mode = ScanText;
        end else if (scan_mode == ScanLtH && ch == ChE) begin
          scan_mode = ScanLtHe;
        end else if (scan_mode == ScanLtHe && ch == ChA) begin
          scan_mode = ScanLtHea;
        end else if (scan_mode == ScanLtHea && ch == ChD) begin
          scan_mode  = ScanHeadSkip;
          head_match = '0;
        end else begin
          scan_mode = ScanBreakTag;
        end
      end
      ScanLtB: begin
        if (ch == ChR) scan_mode = ScanBreakTag;
        else if (ch == ChGt) scan_mode = ScanText;
        else scan_mode = ScanOtherTag;
      end
      ScanLtL, ScanLtD: begin
        if ((scan_mode == ScanLtL && ch == ChI) ||
            (scan_mode == ScanLtD && (ch == ChT || ch == ChL))) scan_mode = ScanListTag;
        else if (ch == ChGt) scan_mode = ScanText;
        else scan_mode = ScanOtherTag;
      end
      ScanBreakTag: begin
        if (ch == ChGt) begin
          add_break(1'b0);
          scan_mode = ScanText;
        end
      end
      ScanListTag: begin
        if (ch == ChGt) begin
          add_break(1'b0);
          add_text(ChStar);
          add_text(ChSpace);
          scan_mode = ScanText;
        end
      end
      ScanOtherTag: begin
        if (ch == ChGt) scan_mode = ScanText;
      end
      ScanHeadSkip: begin
        pos = 55 - 8 * int'(head_match);
        if (ch == HeadClosePat[pos -: 8]) begin
          if (head_match == HeadCloseLen - 3'd1) begin
            head_match = '0;
            scan_mode  = ScanText;
          end else begin
            head_match++;
          end
        end else begin
          head_match = (ch == ChLt) ? 3'd1 : 3'd0;
        end
      end
      default: scan_mode = ScanText;
    endcase

    // End of document: drop any open tag, close the run, start over.
    if (fin) begin
      add_break(1'b1);
      clear_scan();
    end
    if (item_beats.size() > 0) item_beats[item_beats.size()-1].last_of_item = 1'b1;
    expected_beats = {expected_beats, item_beats};
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_beats.delete();
    end else begin
      // Compare first: a beat leaving now never belongs to the byte entering now.
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none actual kind %0d byte %0h len %0h",
                   $time, kind_i, text_byte_i, run_length_i);
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", want.kind, kind_i);
          check_field("text_byte", want.text_byte, text_byte_i);
          check_field("run_length", want.run_length, run_length_i);
          check_field("last_of_item", want.last_of_item, last_of_item_i);
          check_field("document_end", want.document_end, document_end_i);
        end
      end
      if (in_valid_i && !in_stall_i) strip_and_split(in_byte_i, is_final_i);
    end
    error_count_o <= errors;
    results_due_o <= expected_beats.size();
  end

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htsr_pkg::*;

  localparam int unsigned RandomBytes   = 360;
  localparam int unsigned LongRunBytes  = 64;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned IdlePct       = 13;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  in_valid = 1'b0;
  logic [7:0]            in_byte  = 8'h00;
  logic                  is_final = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  kind;
  logic [7:0]            text_byte;
  logic [RunLenBits-1:0] run_length;
  logic                  last_of_item;
  logic                  document_end;
  int                    error_count;
  int                    results_due;

  int unsigned           in_idle_pct  = IdlePct;
  int unsigned           out_idle_pct = IdlePct;
  int unsigned           quiet_cycles = 0;
  logic [7:0]            doc_bytes[$];

  html_tag_strip_run_splitter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .is_final_i     (is_final),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .text_byte_o    (text_byte),
    .run_length_o   (run_length),
    .last_of_item_o (last_of_item),
    .document_end_o (document_end)
  );

  htsr_checker u_htsr_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_byte_i      (in_byte),
    .is_final_i     (is_final),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .kind_i         (kind),
    .text_byte_i    (text_byte),
    .run_length_i   (run_length),
    .last_of_item_i (last_of_item),
    .document_end_i (document_end),
    .error_count_o  (error_count),
    .results_due_o  (results_due)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Stall the result side at random; the rate drops to zero for the long run.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Hang guard: end the run after too many cycles in which no beat moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one byte, idling first at random, and hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    is_final <= fin;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Send the assembled document, flagging its last byte.
  task automatic send_doc();
    foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
  endtask

  // Drop valid and hold until every predicted beat has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  // Append one byte to the document.
  task automatic add_byte(input logic [7:0] b);
    doc_bytes = {doc_bytes, b};
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Build a document out of words, blanks, tags and head sections, with some noise.
  task automatic build_random_doc();
    int unsigned n_tok;
    int unsigned pick;
    logic [7:0]  b;
    doc_bytes.delete();
    n_tok = $urandom_range(1, 12);
    repeat (n_tok) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // word: any printable or high byte except the tag opener
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom_range(33, 255));
          if (b == ChLt) b = 8'h3B;
          add_byte(b);
        end
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(2))
            0:       add_byte(ChSpace);
            1:       add_byte(ChLf);
            default: add_byte(ChTab);
          endcase
        end
      end else if (pick < 50) begin
        add_byte(8'($urandom_range(0, 31)));
      end else if (pick < 85) begin
        add_byte(ChLt);
        case ($urandom_range(25))
          0:  add_str("p");
          1:  add_str("h1");
          2:  add_str("h2");
          3:  add_str("hr");
          4:  add_str("br");
          5:  add_str("b");
          6:  add_str("bx");
          7:  add_str("li");
          8:  add_str("l");
          9:  add_str("lx");
          10: add_str("dt");
          11: add_str("dl");
          12: add_str("dd");
          13: add_str("d");
          14: add_str("a");
          15: add_str("div");
          16: add_str("ul");
          17: add_str("P");
          18: add_str("LI");
          19: add_str("hx");
          20: add_str("hea");
          21: add_str("he");
          22: add_str("h");
          23: add_str("img");
          24: add_str("pre");
          default: ;  // empty tag
        endcase
        if ($urandom_range(99) < 30) begin
          add_byte(ChSpace);
          repeat ($urandom_range(1, 5)) begin
            b = 8'($urandom_range(32, 126));
            if (b == ChGt) b = 8'h3D;
            add_byte(b);
          end
        end
        add_byte(ChGt);
      end else if (pick < 93) begin
        // head section with near-miss closers inside
        add_str("<head");
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(7))
            0:       add_byte(ChLt);
            1:       add_byte(ChSlash);
            2:       add_byte(ChH);
            3:       add_byte(ChE);
            4:       add_byte(ChA);
            5:       add_byte(ChD);
            6:       add_str("</hea");
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
        add_str("</head>");
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    // Now and then cut the document short, often inside a tag.
    if ($urandom_range(99) < 10) begin
      pick = $urandom_range(1, doc_bytes.size());
      while (doc_bytes.size() > pick) void'(doc_bytes.pop_back());
    end
  endtask

  initial begin
    int unsigned random_sent;
    bit          paused;
    random_sent = 0;
    paused      = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, blank collapse, control drop, empty tag,
    // short head names, list tag, and a document ending inside a tag.
    doc_bytes.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str(" \t\n<><hea><he>x<li>a  <h");
    send_doc();
    // one-byte document that is only an open tag
    doc_bytes.delete();
    add_byte(ChLt);
    send_doc();

    // Hold the sender until every result is out.
    drain();

    // Long stretch with no idling on either side, then a break tag and a short word.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    doc_bytes.delete();
    for (int i = 0; i < LongRunBytes; i++) add_byte(8'(8'h61 + i % 26));
    add_str("<p>ab");
    send_doc();
    drain();
    in_idle_pct  = IdlePct;
    out_idle_pct = IdlePct;

    // Random documents; pause the sender once halfway through.
    while (random_sent < RandomBytes) begin
      build_random_doc();
      send_doc();
      random_sent += doc_bytes.size();
      if (!paused && random_sent >= RandomBytes / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && results_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> html_tag_strip_run_splitter.f
hdl/htsr_pkg.sv
hdl/htsr_scan.sv
hdl/htsr_outq.sv
hdl/html_tag_strip_run_splitter.sv
verif/htsr_checker.sv
verif/tb.sv
